/* hw/rtl/rbu_pkg.sv */
// Shared types and constants for the run-length background unpacker.
package rbu_pkg;

   // Default index width and image size
   localparam int unsigned IndexWidthDefault = 16;
   localparam logic [15:0] ImagePixelsReset  = 16'd64000;

   // Run header codes
   localparam logic [7:0] NoopHeader = 8'h80;
   localparam logic [8:0] RepeatBase = 9'd257;

   // Depth of the job queue between front and back
   localparam int unsigned QueueDepth = 2;

   // Width of the packed result word
   localparam int unsigned RspDataWidth = 40;

   // Decoder phase
   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_LITERAL = 2'd1,
      PH_REPEAT  = 2'd2
   } rbu_phase_type;

   // One expansion job: kept pixels of one data byte, starting at pos
   typedef struct packed {
      logic [15:0] pos;
      logic [7:0]  kept;
      logic [7:0]  pixel;
   } rbu_job_type;

endpackage

/* hw/rtl/rbu_front.sv */
// Front end: takes compressed bytes, tracks runs and position, issues expansion jobs.
module rbu_front #(
   parameter int unsigned INDEX_WIDTH = rbu_pkg::IndexWidthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         image_pixels,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte,
   input  logic                req_start,
   output logic                job_valid,
   input  logic                job_ready,
   output rbu_pkg::rbu_job_type job
);

   // Pixel index cap from the index width, saturated to 17 bits
   localparam int unsigned CapRaw   = (INDEX_WIDTH >= 16) ? 32'd65536 : (32'd1 << INDEX_WIDTH);
   localparam logic [16:0] IndexCap = CapRaw[16:0];

   rbu_pkg::rbu_phase_type phase_ff, phase_in, phase_eff;
   logic [7:0]  run_ff, run_in, run_eff, run_dec;
   logic [15:0] pos_ff, pos_in, pos_eff;
   logic        accept;
   logic        take_hdr;
   logic [16:0] limit;
   logic [16:0] avail;
   logic        kept_lit;
   logic [7:0]  rep_kept;
   logic [7:0]  job_kept;

   assign req_ready = job_ready;
   assign accept    = req_valid & job_ready;

   // Apply start of image before the byte is looked at
   always_comb begin
      phase_eff = req_start ? rbu_pkg::PH_HEADER : phase_ff;
      run_eff   = req_start ? 8'd0 : run_ff;
      pos_eff   = req_start ? 16'd0 : pos_ff;
      take_hdr  = (run_eff == 8'd0) ||
                  ((phase_eff != rbu_pkg::PH_LITERAL) && (phase_eff != rbu_pkg::PH_REPEAT));
      run_dec   = run_eff - 8'd1;
   end

   // Count the pixels of this byte that still fall inside the image
   always_comb begin
      limit    = ({1'b0, image_pixels} < IndexCap) ? {1'b0, image_pixels} : IndexCap;
      kept_lit = ({1'b0, pos_eff} < limit);
      avail    = limit - {1'b0, pos_eff};
      // Nothing is kept once the position is at or past the image end
      rep_kept = !kept_lit ? 8'd0 :
                 (avail < {9'd0, run_eff}) ? avail[7:0] : run_eff;
      job_kept = (phase_eff == rbu_pkg::PH_LITERAL) ? {7'd0, kept_lit} : rep_kept;
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      run_in   = run_ff;
      pos_in   = pos_ff;
      if (accept) begin
         phase_in = phase_eff;
         run_in   = run_eff;
         pos_in   = pos_eff;
         if (take_hdr) begin
            if (req_byte == rbu_pkg::NoopHeader) begin
               phase_in = rbu_pkg::PH_HEADER;
               run_in   = 8'd0;
            end else if (!req_byte[7]) begin
               phase_in = rbu_pkg::PH_LITERAL;
               run_in   = req_byte + 8'd1;
            end else begin
               phase_in = rbu_pkg::PH_REPEAT;
               run_in   = 8'(rbu_pkg::RepeatBase - {1'b0, req_byte});
            end
         end else begin
            pos_in = pos_eff + {8'd0, job_kept};
            case (phase_eff)
               rbu_pkg::PH_LITERAL: begin
                  run_in   = run_dec;
                  phase_in = (run_dec == 8'd0) ? rbu_pkg::PH_HEADER : rbu_pkg::PH_LITERAL;
               end
               rbu_pkg::PH_REPEAT: begin
                  run_in   = 8'd0;
                  phase_in = rbu_pkg::PH_HEADER;
               end
               default: begin
                  phase_in = rbu_pkg::PH_HEADER;
               end
            endcase
         end
      end
   end

   // Job output: data bytes with at least one kept pixel
   always_comb begin
      job_valid  = accept && !take_hdr && (job_kept != 8'd0);
      job.pos    = pos_eff;
      job.kept   = job_kept;
      job.pixel  = req_byte;
   end

   // Hold decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rbu_pkg::PH_HEADER;
         run_ff   <= 8'd0;
         pos_ff   <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

/* hw/rtl/rbu_queue.sv */
// Short job queue that decouples the front end from the pixel expander.
module rbu_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  rbu_pkg::rbu_job_type push_job,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output rbu_pkg::rbu_job_type pop_job
);

   localparam int unsigned Depth    = rbu_pkg::QueueDepth;
   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   rbu_pkg::rbu_job_type entry_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/rbu_back.sv */
// Back end: expands queued jobs into one- or two-pixel results.
module rbu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  rbu_pkg::rbu_job_type job,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [rbu_pkg::RspDataWidth-1:0] rsp_data,
   output logic                 rsp_last
);

   logic [7:0]  done_ff, done_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [rbu_pkg::RspDataWidth-1:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [7:0]  left;
   logic        pair;
   logic        last;
   logic        emit;
   logic [15:0] index;
   logic [7:0]  second;

   // Pick the next pair from the head job
   always_comb begin
      left      = job.kept - done_ff;
      pair      = (left > 8'd1);
      last      = (left <= 8'd2);
      emit      = job_valid && (!rsp_valid_ff || rsp_ready);
      job_ready = emit && last;
      index     = job.pos + {8'd0, done_ff};
      second    = pair ? job.pixel : 8'd0;
   end

   // Load the output register, or drop it once taken
   always_comb begin
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         done_in      = last ? 8'd0 : done_ff + 8'd2;
         rsp_valid_in = 1'b1;
         rsp_last_in  = last;
         rsp_data_in  = {6'd0, second[7], second[6:5], second[4:0],
                         job.pixel[7], job.pixel[6:5], job.pixel[4:0],
                         pair ? 2'd2 : 2'd1, index};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

/* hw/rtl/rle_background_unpack.sv */
// Top level of the run-length background unpacker: config register, front, queue, back.
// Takes one compressed byte per cycle. Header bytes give no result. A literal data byte
// gives one single-pixel result, registered in the job queue, then in the output register;
// literal runs stream at one byte per cycle. A repeat data byte with n pixels inside the
// image gives ceil(n/2) results, one per cycle while rsp_tready is high, issued by the
// pixel expander; a two-entry job queue lets the front keep taking header bytes meanwhile,
// and requests stall only when that queue is full. Pixels at or past image_pixels (or
// 2^INDEX_WIDTH) are dropped; write csr only while no results are pending.
module rle_background_unpack #(
   parameter int unsigned INDEX_WIDTH = rbu_pkg::IndexWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   // request: data_byte[7:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // request: start_image[0]
   input  logic        req_tuser,
   // result: pixel_index[15:0], pixel_count[17:16], color_first[22:18], depth_first[24:23],
   // walk_first[25], color_second[30:26], depth_second[32:31], walk_second[33], zero[39:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [rbu_pkg::RspDataWidth-1:0] rsp_tdata,
   // result: run_end
   output logic        rsp_tlast,
   // image_pixels write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0]          image_pixels_ff, image_pixels_in;
   logic                 fr_job_valid, fr_job_ready;
   rbu_pkg::rbu_job_type fr_job;
   logic                 bk_job_valid, bk_job_ready;
   rbu_pkg::rbu_job_type bk_job;

   // Image size register
   assign csr_ready = 1'b1;
   assign image_pixels_in = (csr_valid && csr_ready) ? csr_data : image_pixels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_pixels_ff <= rbu_pkg::ImagePixelsReset;
      end else begin
         image_pixels_ff <= image_pixels_in;
      end
   end

   rbu_front #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .image_pixels (image_pixels_ff),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_byte     (req_tdata),
      .req_start    (req_tuser),
      .job_valid    (fr_job_valid),
      .job_ready    (fr_job_ready),
      .job          (fr_job)
   );

   rbu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_job_valid),
      .push_ready (fr_job_ready),
      .push_job   (fr_job),
      .pop_valid  (bk_job_valid),
      .pop_ready  (bk_job_ready),
      .pop_job    (bk_job)
   );

   rbu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (bk_job_valid),
      .job_ready (bk_job_ready),
      .job       (bk_job),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

   // A result carries one or two pixels
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17:16] == 2'd1 || rsp_tdata[17:16] == 2'd2))
      else $error("bad pixel count");

   // Only the last result of a byte may carry a single pixel
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[17:16] == 2'd2))
      else $error("single pixel before run end");

   // Second pixel fields are clear on single-pixel results
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[17:16] == 2'd1) |-> (rsp_tdata[33:26] == 8'd0))
      else $error("stray second pixel");

   // No result reaches past the image
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[15:0]} + {15'd0, rsp_tdata[17:16]}
                      <= {1'b0, image_pixels_ff})
      || (rsp_tdata[17:16] != 2'd1 && rsp_tdata[17:16] != 2'd2))
      else $error("pixel index past image");

endmodule

/* bench/tb.sv */
// Self-checking bench for the run-length background unpacker: directed runs, random streams, stalls.
module tb;

   // Longest stretch without any handshake before the run is abandoned
   localparam int unsigned StallLimit     = 2000;
   // A repeat byte yields at most this many pair results
   localparam int unsigned MaxPairResults = 64;
   localparam int unsigned ReportLimit    = 10;
   localparam int unsigned SettleCycles   = 16;
   localparam int unsigned HoldOffCycles  = 300;
   localparam int unsigned RandomBytes    = 30;

   // Result word as packed on rsp_tdata, lowest field last
   typedef struct packed {
      logic [5:0]  pad;
      logic        walk_second;
      logic [1:0]  depth_second;
      logic [4:0]  color_second;
      logic        walk_first;
      logic [1:0]  depth_first;
      logic [4:0]  color_first;
      logic [1:0]  pixel_count;
      logic [15:0] pixel_index;
   } pixel_word_type;

   typedef struct {
      pixel_word_type word;
      logic           run_end;
   } pixel_result_type;

   typedef struct {
      logic [7:0] data_byte;
      logic       start_image;
   } byte_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [rbu_pkg::RspDataWidth-1:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // Pending compressed bytes and the pixels they must produce
   byte_request_type compressed_bytes[$];
   pixel_result_type expected_pixels[$];
   int unsigned      queued_bytes = 0;
   int unsigned      taken_bytes = 0;

   // Decoder state mirrored by the bench
   rbu_pkg::rbu_phase_type decode_phase = rbu_pkg::PH_HEADER;
   logic [7:0]    run_left = '0;
   logic [15:0]   next_pixel = '0;
   logic [15:0]   image_pixels_cfg = rbu_pkg::ImagePixelsReset;

   bit          req_accepted = 1'b0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          hold_armed = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_cycles = 0;
   int unsigned idle_cycles = 0;
   int unsigned mismatch_count = 0;

   rle_background_unpack #(
      .INDEX_WIDTH (rbu_pkg::IndexWidthDefault)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Build one result carrying one or two copies of a pixel byte
   function automatic pixel_result_type pack_pixels(logic [15:0] index, logic [1:0] count,
                                                    logic [7:0] pixel);
      pixel_result_type r;
      r.word = '0;
      r.word.pixel_index = index;
      r.word.pixel_count = count;
      r.word.color_first = pixel[4:0];
      r.word.depth_first = pixel[6:5];
      r.word.walk_first  = pixel[7];
      if (count == 2'd2) begin
         r.word.color_second = pixel[4:0];
         r.word.depth_second = pixel[6:5];
         r.word.walk_second  = pixel[7];
      end
      r.run_end = 1'b0;
      return r;
   endfunction

   // Advance the decoder by one compressed byte and queue the pixels it yields
   function automatic void decode_byte(logic [7:0] b, logic start);
      pixel_result_type batch[$];
      pixel_result_type r;
      logic [15:0]      first;
      logic [1:0]       count;
      int unsigned      left;
      if (start) begin
         decode_phase = rbu_pkg::PH_HEADER;
         run_left = '0;
         next_pixel = '0;
      end
      // Header byte: open a run, no pixels
      if (run_left == 0 || (decode_phase != rbu_pkg::PH_LITERAL &&
                            decode_phase != rbu_pkg::PH_REPEAT)) begin
         if (b == rbu_pkg::NoopHeader) begin
            decode_phase = rbu_pkg::PH_HEADER;
            run_left = '0;
         end else if (b < rbu_pkg::NoopHeader) begin
            decode_phase = rbu_pkg::PH_LITERAL;
            run_left = b + 8'd1;
         end else begin
            decode_phase = rbu_pkg::PH_REPEAT;
            run_left = 8'(rbu_pkg::RepeatBase - {1'b0, b});
         end
         return;
      end
      if (decode_phase == rbu_pkg::PH_LITERAL) begin
         if (next_pixel < image_pixels_cfg) begin
            r = pack_pixels(next_pixel, 2'd1, b);
            r.run_end = 1'b1;
            expected_pixels.insert(expected_pixels.size(), r);
            next_pixel = next_pixel + 16'd1;
         end
         run_left = run_left - 8'd1;
         if (run_left == 0)
            decode_phase = rbu_pkg::PH_HEADER;
         return;
      end
      // Repeat run: expand into pairs, stop at the image edge
      left = run_left;
      while (left > 0 && batch.size() < MaxPairResults && next_pixel < image_pixels_cfg) begin
         first = next_pixel;
         count = 2'd1;
         next_pixel = next_pixel + 16'd1;
         left--;
         if (left > 0 && next_pixel < image_pixels_cfg) begin
            count = 2'd2;
            next_pixel = next_pixel + 16'd1;
            left--;
         end
         batch.insert(batch.size(), pack_pixels(first, count, b));
         if (count == 2'd1)
            break;
      end
      run_left = '0;
      decode_phase = rbu_pkg::PH_HEADER;
      if (batch.size() > 0)
         batch[batch.size() - 1].run_end = 1'b1;
      foreach (batch[i])
         expected_pixels.insert(expected_pixels.size(), batch[i]);
   endfunction

   function automatic void note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
         $display("%s", msg);
   endfunction

   function automatic void compare_field(string name, logic [15:0] index,
                                         int unsigned want, int unsigned got);
      if (want != got)
         note_failure($sformatf("pixel %0d: %s expected %0d, got %0d", index, name, want, got));
   endfunction

   // Compare one returned result against the oldest expected one
   function automatic void check_result(pixel_word_type got, logic last);
      pixel_result_type want;
      if (expected_pixels.size() == 0) begin
         note_failure($sformatf("unexpected result %h last %0d", got, last));
         return;
      end
      want = expected_pixels.pop_front();
      compare_field("pixel_index", want.word.pixel_index, want.word.pixel_index,
                    got.pixel_index);
      compare_field("pixel_count", want.word.pixel_index, want.word.pixel_count,
                    got.pixel_count);
      compare_field("color_first", want.word.pixel_index, want.word.color_first,
                    got.color_first);
      compare_field("depth_first", want.word.pixel_index, want.word.depth_first,
                    got.depth_first);
      compare_field("walk_first", want.word.pixel_index, want.word.walk_first,
                    got.walk_first);
      compare_field("color_second", want.word.pixel_index, want.word.color_second,
                    got.color_second);
      compare_field("depth_second", want.word.pixel_index, want.word.depth_second,
                    got.depth_second);
      compare_field("walk_second", want.word.pixel_index, want.word.walk_second,
                    got.walk_second);
      compare_field("pad", want.word.pixel_index, want.word.pad, got.pad);
      compare_field("run_end", want.word.pixel_index, want.run_end, last);
   endfunction

   // Sample handshakes, check results and track the decoder
   always @(posedge clock) begin
      if (reset) begin
         decode_phase = rbu_pkg::PH_HEADER;
         run_left = '0;
         next_pixel = '0;
         image_pixels_cfg = rbu_pkg::ImagePixelsReset;
         expected_pixels.delete();
         req_accepted = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result(pixel_word_type'(rsp_tdata), rsp_tlast);
         if (csr_valid && csr_ready)
            image_pixels_cfg = csr_data;
         req_accepted = req_tvalid && req_tready;
         if (req_accepted) begin
            decode_byte(req_tdata, req_tuser);
            taken_bytes++;
         end
      end
   end

   // Offer the next compressed byte, idling at random
   always @(negedge clock) begin
      byte_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (compressed_bytes.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            item = compressed_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.data_byte;
            req_tuser  <= item.start_image;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Accept results, stalling at random or holding off entirely
   always @(negedge clock) begin
      rsp_tready <= (hold_cycles == 0) && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Load and count down a receiver hold-off
   always @(negedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_cycles <= HoldOffCycles;
         hold_done   <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // Abandon the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("rle_background_unpack regression: fail");
         $finish;
      end
   end

   function automatic void queue_byte(logic [7:0] b, logic start);
      byte_request_type item;
      item.data_byte = b;
      item.start_image = start;
      compressed_bytes.insert(compressed_bytes.size(), item);
      queued_bytes++;
   endfunction

   // Hold until every byte is taken and every pixel has come back
   task automatic wait_idle();
      while (taken_bytes != queued_bytes || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_image_pixels(logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed runs with random content, plus noise and cut-short runs
   task automatic queue_random_stream(int unsigned budget);
      int unsigned target;
      int unsigned pick;
      int unsigned header;
      int unsigned count;
      logic        start;
      target = queued_bytes + budget;
      while (queued_bytes < target) begin
         pick = $urandom_range(99);
         start = ($urandom_range(9) == 0);
         if (pick < 8) begin
            queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (pick < 48) begin
            header = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7);
            count = header + 1;
            if ($urandom_range(19) == 0)
               count = $urandom_range(header);
            queue_byte(8'(header), start);
            repeat (count) queue_byte(8'($urandom_range(255)), 1'b0);
         end else if (pick < 92) begin
            header = ($urandom_range(3) == 0) ? $urandom_range(129, 255)
                                              : $urandom_range(240, 255);
            queue_byte(8'(header), start);
            queue_byte(8'($urandom_range(255)), 1'b0);
         end else begin
            queue_byte(rbu_pkg::NoopHeader, start);
         end
      end
   endtask

   initial begin
      int unsigned send_pct[4];
      int unsigned stall_pct[4];
      send_pct  = '{0, 76, 0, 10};
      stall_pct = '{0, 0, 76, 10};
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed runs at the reset image size
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h02, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(rbu_pkg::NoopHeader, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h55, 1'b0);
      queue_byte(8'hFE, 1'b0);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h81, 1'b0);
      queue_byte(8'hE3, 1'b0);
      // New image in the middle of a literal run: the byte is a header
      queue_byte(8'h03, 1'b0);
      queue_byte(8'h9C, 1'b0);
      queue_byte(8'hFD, 1'b1);
      queue_byte(8'h1F, 1'b0);
      wait_idle();

      // Image edge inside a repeat run, then literal and repeat bytes past it
      write_image_pixels(16'd5);
      queue_byte(8'hFA, 1'b1);
      queue_byte(8'h3C, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'hC4, 1'b0);
      queue_byte(8'h5B, 1'b0);
      queue_byte(8'hFE, 1'b0);
      queue_byte(8'h66, 1'b0);
      wait_idle();

      // One-pixel image: a pair shrinks to one pixel
      write_image_pixels(16'd1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h99, 1'b0);
      queue_byte(8'h01, 1'b1);
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b0);
      wait_idle();

      // Zero image size drops everything
      write_image_pixels(16'd0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hA5, 1'b0);
      queue_byte(8'hF0, 1'b0);
      queue_byte(8'h5A, 1'b0);
      wait_idle();

      // Random phases under different idling and image sizes
      for (int unsigned ph = 0; ph < 4; ph++) begin
         req_idle_pct  = send_pct[ph];
         rsp_stall_pct = stall_pct[ph];
         case (ph)
            0: write_image_pixels(16'hFFFF);
            1: write_image_pixels(16'($urandom_range(16, 400)));
            2: write_image_pixels(16'($urandom_range(1, 64)));
            default: write_image_pixels(16'($urandom_range(400, 2000)));
         endcase
         if (ph == 0) begin
            // Block the receiver while long repeat runs keep arriving
            @(posedge clock);
            hold_armed = 1'b1;
            queue_byte(8'h81, 1'b1);
            queue_byte(8'($urandom_range(255)), 1'b0);
            repeat (3) begin
               queue_byte(8'h81, 1'b0);
               queue_byte(8'($urandom_range(255)), 1'b0);
            end
         end
         queue_random_stream(RandomBytes);
         wait_idle();
      end

      // Odd image edge reached across two full-length repeat runs
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      write_image_pixels(16'd201);
      queue_byte(8'h81, 1'b1);
      queue_byte(8'($urandom_range(255)), 1'b0);
      queue_byte(8'h81, 1'b0);
      queue_byte(8'($urandom_range(255)), 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h77, 1'b0);
      wait_idle();

      if (mismatch_count == 0)
         $display("rle_background_unpack regression: pass");
      else
         $display("rle_background_unpack regression: fail");
      $finish;
   end

endmodule
